/* rtl/sai_pkg.sv */
// sai_pkg: shared constants and types for the sorted array intersection unit
// no dependencies

`default_nettype none

package sai_pkg;

    localparam int DEPTH = 32;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int LW    = CW + 2;

    localparam logic [1:0] KIND_A     = 2'd0;
    localparam logic [1:0] KIND_B     = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;

    typedef logic [31:0]   t_word;
    typedef logic [AW-1:0] t_addr;
    typedef logic [CW-1:0] t_count;
    typedef logic [LW-1:0] t_idx;

endpackage

`default_nettype wire

/* rtl/sorted_array_intersection_unit.sv */
// sorted_array_intersection_unit: loads two lists, sorts them and emits their common values
// depends on sai_pkg

`default_nettype none

// Usage
//   Input: an item transfers on a rising edge with i_start high and o_busy low.
//   i_kind selects append to list A, append to list B, or start; kind 3 is ignored.
//   Appends leave o_busy low, so the unit is ready again in the next cycle.
//   An append to a full list (sai_pkg::DEPTH entries) is dropped and flags overflow.
//   A start sorts list A, then list B, with a bottom-up merge sort that runs
//   through one shared signed comparator and one memory write port: each
//   element of a pass is read, then compared and written, over ceil(log2(n))
//   passes rounded up to an even count. The two-pointer walk then reads and
//   compares at each step, at most count_a + count_b steps. o_busy stays high for the
//   whole start.
//   Output: each result is shown for one cycle with o_valid high; the receiver
//   cannot stall. Common values come in ascending order, the final one with o_last.
//   An empty intersection gives a single result with o_none_found and o_last set.
//   After a start both lists are empty and the overflow flag is cleared.
//   Reset (synchronous, active low) empties both lists and clears overflow;
//   list contents are not cleared and are never used before being written.

module sorted_array_intersection_unit (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    output logic               o_busy,
    input  wire  [1:0]         i_kind,
    input  wire  signed [31:0] i_value,
    output logic               o_valid,
    output logic signed [31:0] o_value_res,
    output logic               o_none_found,
    output logic               o_last,
    output logic               o_overflow
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PASS  = 3'd1;
    localparam logic [2:0] S_PAIR  = 3'd2;
    localparam logic [2:0] S_MREAD = 3'd3;
    localparam logic [2:0] S_MCMP  = 3'd4;
    localparam logic [2:0] S_WREAD = 3'd5;
    localparam logic [2:0] S_WCMP  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    // memories
    sai_pkg::t_word r_mem_a [sai_pkg::DEPTH];
    sai_pkg::t_word r_mem_b [sai_pkg::DEPTH];
    sai_pkg::t_word r_mem_s [sai_pkg::DEPTH];
    sai_pkg::t_word r_a_q0, r_a_q1, r_b_q0, r_b_q1, r_s_q0, r_s_q1;

    // control
    logic [2:0]       r_state, n_state;
    sai_pkg::t_count  r_cnt_a, n_cnt_a;
    sai_pkg::t_count  r_cnt_b, n_cnt_b;
    logic             r_ovf, n_ovf;
    logic             r_valid, n_valid;

    // sequencer working registers
    sai_pkg::t_idx    r_width, n_width;
    sai_pkg::t_idx    r_lo, n_lo;
    sai_pkg::t_idx    r_mid, n_mid;
    sai_pkg::t_idx    r_hi, n_hi;
    sai_pkg::t_idx    r_p, n_p;
    sai_pkg::t_idx    r_q, n_q;
    sai_pkg::t_idx    r_w, n_w;
    logic             r_in_s, n_in_s;
    logic             r_sel, n_sel;
    sai_pkg::t_word   r_pend, n_pend;
    logic             r_have_pend, n_have_pend;

    // result registers
    sai_pkg::t_word   r_out_value, n_out_value;
    logic             r_out_none, n_out_none;
    logic             r_out_last, n_out_last;
    logic             r_out_ovf, n_out_ovf;

    // memory ports
    sai_pkg::t_addr   n_ra0, n_ra1, n_waddr;
    sai_pkg::t_word   n_wdata;
    logic             n_we_a, n_we_b, n_we_s;

    // shared datapath
    sai_pkg::t_idx    w_len;
    sai_pkg::t_idx    w_lo_w, w_lo_2w;
    sai_pkg::t_word   w_d0, w_d1;
    sai_pkg::t_word   w_cmp_x, w_cmp_y;
    logic             w_eq, w_lt;
    logic             w_take_p;

    assign w_len   = r_sel ? sai_pkg::t_idx'(r_cnt_b) : sai_pkg::t_idx'(r_cnt_a);
    assign w_lo_w  = r_lo + r_width;
    assign w_lo_2w = r_lo + (r_width << 1);
    assign w_d0    = r_in_s ? r_s_q0 : (r_sel ? r_b_q0 : r_a_q0);
    assign w_d1    = r_in_s ? r_s_q1 : (r_sel ? r_b_q1 : r_a_q1);
    // one signed comparator serves both the merge and the walk
    assign w_cmp_x = (r_state == S_WCMP) ? r_a_q0 : w_d0;
    assign w_cmp_y = (r_state == S_WCMP) ? r_b_q1 : w_d1;
    assign w_eq    = (w_cmp_x == w_cmp_y);
    assign w_lt    = ($signed(w_cmp_x) < $signed(w_cmp_y));
    assign w_take_p = (r_p < r_mid) && ((r_q >= r_hi) || w_lt || w_eq);

    always_comb begin
        n_state     = r_state;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_ovf       = r_ovf;
        n_valid     = 1'b0;
        n_width     = r_width;
        n_lo        = r_lo;
        n_mid       = r_mid;
        n_hi        = r_hi;
        n_p         = r_p;
        n_q         = r_q;
        n_w         = r_w;
        n_in_s      = r_in_s;
        n_sel       = r_sel;
        n_pend      = r_pend;
        n_have_pend = r_have_pend;
        n_out_value = r_out_value;
        n_out_none  = r_out_none;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        n_ra0       = '0;
        n_ra1       = '0;
        n_waddr     = '0;
        n_wdata     = i_value;
        n_we_a      = 1'b0;
        n_we_b      = 1'b0;
        n_we_s      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    priority if (i_kind == sai_pkg::KIND_A) begin
                        if (r_cnt_a >= sai_pkg::t_count'(sai_pkg::DEPTH)) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_waddr = r_cnt_a[sai_pkg::AW-1:0];
                            n_we_a  = 1'b1;
                            n_cnt_a = r_cnt_a + 1'b1;
                        end
                    end else if (i_kind == sai_pkg::KIND_B) begin
                        if (r_cnt_b >= sai_pkg::t_count'(sai_pkg::DEPTH)) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_waddr = r_cnt_b[sai_pkg::AW-1:0];
                            n_we_b  = 1'b1;
                            n_cnt_b = r_cnt_b + 1'b1;
                        end
                    end else if (i_kind == sai_pkg::KIND_START) begin
                        n_sel       = 1'b0;
                        n_width     = sai_pkg::t_idx'(1);
                        n_in_s      = 1'b0;
                        n_have_pend = 1'b0;
                        n_state     = S_PASS;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_PASS: begin
                // odd pass counts get one more pass, a plain copy back from scratch
                if ((r_width < w_len) || r_in_s) begin
                    n_lo    = '0;
                    n_state = S_PAIR;
                end else if (!r_sel) begin
                    n_sel   = 1'b1;
                    n_width = sai_pkg::t_idx'(1);
                end else begin
                    n_p     = '0;
                    n_q     = '0;
                    n_state = S_WREAD;
                end
            end
            S_PAIR: begin
                if (r_lo >= w_len) begin
                    n_width = r_width << 1;
                    n_in_s  = !r_in_s;
                    n_state = S_PASS;
                end else begin
                    n_mid   = (w_lo_w < w_len) ? w_lo_w : w_len;
                    n_hi    = (w_lo_2w < w_len) ? w_lo_2w : w_len;
                    n_p     = r_lo;
                    n_q     = (w_lo_w < w_len) ? w_lo_w : w_len;
                    n_w     = r_lo;
                    n_state = S_MREAD;
                end
            end
            S_MREAD: begin
                n_ra0 = r_p[sai_pkg::AW-1:0];
                n_ra1 = r_q[sai_pkg::AW-1:0];
                if (r_w >= r_hi) begin
                    n_lo    = r_hi;
                    n_state = S_PAIR;
                end else begin
                    n_state = S_MCMP;
                end
            end
            S_MCMP: begin
                n_waddr = r_w[sai_pkg::AW-1:0];
                n_wdata = w_take_p ? w_d0 : w_d1;
                if (r_in_s) begin
                    n_we_a = !r_sel;
                    n_we_b = r_sel;
                end else begin
                    n_we_s = 1'b1;
                end
                if (w_take_p) begin
                    n_p = r_p + 1'b1;
                end else begin
                    n_q = r_q + 1'b1;
                end
                n_w     = r_w + 1'b1;
                n_state = S_MREAD;
            end
            S_WREAD: begin
                n_ra0 = r_p[sai_pkg::AW-1:0];
                n_ra1 = r_q[sai_pkg::AW-1:0];
                if ((r_p >= sai_pkg::t_idx'(r_cnt_a)) || (r_q >= sai_pkg::t_idx'(r_cnt_b))) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_WCMP;
                end
            end
            S_WCMP: begin
                // a match is held back one step so the final one can carry last
                if (w_eq) begin
                    if (r_have_pend) begin
                        n_valid     = 1'b1;
                        n_out_value = r_pend;
                        n_out_none  = 1'b0;
                        n_out_last  = 1'b0;
                        n_out_ovf   = r_ovf;
                    end
                    n_pend      = r_a_q0;
                    n_have_pend = 1'b1;
                    n_p         = r_p + 1'b1;
                    n_q         = r_q + 1'b1;
                end else if (w_lt) begin
                    n_p = r_p + 1'b1;
                end else begin
                    n_q = r_q + 1'b1;
                end
                n_state = S_WREAD;
            end
            S_DONE: begin
                n_valid     = 1'b1;
                n_out_value = r_have_pend ? r_pend : '0;
                n_out_none  = !r_have_pend;
                n_out_last  = 1'b1;
                n_out_ovf   = r_ovf;
                n_cnt_a     = '0;
                n_cnt_b     = '0;
                n_ovf       = 1'b0;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (n_we_a) begin
            r_mem_a[n_waddr] <= n_wdata;
        end
        r_a_q0 <= r_mem_a[n_ra0];
        r_a_q1 <= r_mem_a[n_ra1];
    end

    always_ff @(posedge i_clk) begin
        if (n_we_b) begin
            r_mem_b[n_waddr] <= n_wdata;
        end
        r_b_q0 <= r_mem_b[n_ra0];
        r_b_q1 <= r_mem_b[n_ra1];
    end

    always_ff @(posedge i_clk) begin
        if (n_we_s) begin
            r_mem_s[n_waddr] <= n_wdata;
        end
        r_s_q0 <= r_mem_s[n_ra0];
        r_s_q1 <= r_mem_s[n_ra1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
            r_ovf   <= n_ovf;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_width     <= n_width;
        r_lo        <= n_lo;
        r_mid       <= n_mid;
        r_hi        <= n_hi;
        r_p         <= n_p;
        r_q         <= n_q;
        r_w         <= n_w;
        r_in_s      <= n_in_s;
        r_sel       <= n_sel;
        r_pend      <= n_pend;
        r_have_pend <= n_have_pend;
        r_out_value <= n_out_value;
        r_out_none  <= n_out_none;
        r_out_last  <= n_out_last;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_value_res  = $signed(r_out_value);
    assign o_none_found = r_out_none;
    assign o_last       = r_out_last;
    assign o_overflow   = r_out_ovf;

    // assertions
    a_none_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_none_found) |-> o_last)
        else $error("empty result not marked last");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> o_busy)
        else $error("non-final result while idle");

    a_lists_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (!o_busy && r_cnt_a == '0 && r_cnt_b == '0 && !r_ovf))
        else $error("lists not emptied after final result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= sai_pkg::t_count'(sai_pkg::DEPTH)) &&
        (r_cnt_b <= sai_pkg::t_count'(sai_pkg::DEPTH)))
        else $error("list count beyond depth");

endmodule

`default_nettype wire

/* tb/sorted_array_intersection_unit_tb.sv */
// sorted_array_intersection_unit_tb: self-checking testbench for the sorted array intersection unit
// drives load and start transfers, predicts the common values and compares every result strobe
// depends on sai_pkg and sorted_array_intersection_unit

`timescale 1ns / 100ps

module sorted_array_intersection_unit_tb;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [31:0] WORD_MIN   = 32'h8000_0000;
    localparam logic [31:0] WORD_MAX   = 32'h7fff_ffff;

    typedef struct {
        logic signed [31:0] value;
        logic               none_found;
        logic               last;
        logic               overflow;
    } t_common_res;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic [1:0]         i_kind  = sai_pkg::KIND_A;
    logic signed [31:0] i_value = '0;
    logic               o_busy;
    logic               o_valid;
    logic signed [31:0] o_value_res;
    logic               o_none_found;
    logic               o_last;
    logic               o_overflow;

    int          held_a[$];
    int          held_b[$];
    bit          overflow_pending;
    t_common_res common_q[$];
    t_common_res exp_res;
    int          fail_count;
    int          items_sent;
    int          idle_pct;

    sorted_array_intersection_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_kind       (i_kind),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .o_value_res  (o_value_res),
        .o_none_found (o_none_found),
        .o_last       (o_last),
        .o_overflow   (o_overflow)
    );

    always #6 i_clk = ~i_clk;

    // held lists are kept in ascending order as they load
    function automatic void hold_value(ref int held[$], input int v);
        int pos;
        pos = 0;
        if (held.size() >= sai_pkg::DEPTH) begin
            overflow_pending = 1'b1;
        end else begin
            while (pos < held.size() && held[pos] <= v)
                pos++;
            held.insert(pos, v);
        end
    endfunction

    function automatic void predict_intersection(input logic [1:0] kind,
                                                 input logic signed [31:0] value);
        int          ia;
        int          ib;
        int          n;
        t_common_res res;
        ia = 0;
        ib = 0;
        n  = 0;
        case (kind)
            sai_pkg::KIND_A: begin
                hold_value(held_a, value);
            end
            sai_pkg::KIND_B: begin
                hold_value(held_b, value);
            end
            sai_pkg::KIND_START: begin
                while (ia < held_a.size() && ib < held_b.size() && n < sai_pkg::DEPTH) begin
                    if (held_a[ia] == held_b[ib]) begin
                        res.value      = held_a[ia];
                        res.none_found = 1'b0;
                        res.last       = 1'b0;
                        res.overflow   = overflow_pending;
                        common_q.push_back(res);
                        n++;
                        ia++;
                        ib++;
                    end else if (held_a[ia] < held_b[ib]) begin
                        ia++;
                    end else begin
                        ib++;
                    end
                end
                if (n == 0) begin
                    res.value      = '0;
                    res.none_found = 1'b1;
                    res.last       = 1'b1;
                    res.overflow   = overflow_pending;
                    common_q.push_back(res);
                end else begin
                    common_q[common_q.size() - 1].last = 1'b1;
                end
                held_a.delete();
                held_b.delete();
                overflow_pending = 1'b0;
            end
            default: begin
            end
        endcase
    endfunction

    task automatic idle_gap();
        if ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            repeat ($urandom_range(3)) @(negedge i_clk);
        end
    endtask

    task automatic send_item(input logic [1:0] kind, input logic signed [31:0] value);
        @(negedge i_clk);
        i_start <= 1'b1;
        i_kind  <= kind;
        i_value <= value;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        predict_intersection(kind, value);
        if (kind != KIND_UNUSED)
            items_sent++;
        idle_gap();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (common_q.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual value_res %0d",
                         $time, o_value_res);
                fail_count++;
            end else begin
                exp_res = common_q.pop_front();
                if (o_value_res !== exp_res.value) begin
                    $display("%0t ns: value_res mismatch, expected %0d, actual %0d",
                             $time, exp_res.value, o_value_res);
                    fail_count++;
                end
                if (o_none_found !== exp_res.none_found) begin
                    $display("%0t ns: none_found mismatch, expected %0b, actual %0b",
                             $time, exp_res.none_found, o_none_found);
                    fail_count++;
                end
                if (o_last !== exp_res.last) begin
                    $display("%0t ns: last mismatch, expected %0b, actual %0b",
                             $time, exp_res.last, o_last);
                    fail_count++;
                end
                if (o_overflow !== exp_res.overflow) begin
                    $display("%0t ns: overflow mismatch, expected %0b, actual %0b",
                             $time, exp_res.overflow, o_overflow);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_empty_start();
        send_item(sai_pkg::KIND_START, 32'sd17);
    endtask

    task automatic test_extreme_values();
        send_item(sai_pkg::KIND_A, WORD_MAX);
        send_item(sai_pkg::KIND_A, WORD_MIN);
        send_item(sai_pkg::KIND_A, 32'sd0);
        send_item(sai_pkg::KIND_A, -32'sd1);
        send_item(sai_pkg::KIND_B, -32'sd1);
        send_item(sai_pkg::KIND_B, WORD_MIN);
        send_item(sai_pkg::KIND_B, 32'sd5);
        send_item(sai_pkg::KIND_B, WORD_MAX);
        send_item(sai_pkg::KIND_START, -32'sd1);
    endtask

    task automatic test_duplicates_and_unused_kind();
        send_item(sai_pkg::KIND_A, 32'sd7);
        send_item(sai_pkg::KIND_B, 32'sd7);
        send_item(KIND_UNUSED, 32'sd7);
        send_item(sai_pkg::KIND_A, 32'sd7);
        send_item(sai_pkg::KIND_A, 32'sd7);
        send_item(sai_pkg::KIND_B, 32'sd7);
        send_item(sai_pkg::KIND_START, 32'sd0);
    endtask

    task automatic test_one_list_empty();
        send_item(sai_pkg::KIND_A, 32'sd0);
        send_item(sai_pkg::KIND_START, 32'sd0);
        send_item(sai_pkg::KIND_B, 32'sd3);
        send_item(sai_pkg::KIND_START, 32'sd0);
    endtask

    // both lists overfilled, all held values common: the most results per start
    task automatic test_full_lists();
        for (int k = sai_pkg::DEPTH; k >= 0; k--)
            send_item(sai_pkg::KIND_A, k);
        for (int k = 1; k <= sai_pkg::DEPTH + 2; k++)
            send_item(sai_pkg::KIND_B, k);
        send_item(sai_pkg::KIND_START, 32'sd0);
    endtask

    function automatic logic [31:0] pick_value(input int mode);
        logic [31:0] v;
        case (mode)
            0: v = $urandom_range(12) - 6;
            1: v = $urandom;
            default: begin
                case ($urandom_range(5))
                    0: v = WORD_MIN;
                    1: v = WORD_MAX;
                    2: v = WORD_MIN + 1;
                    3: v = WORD_MAX - 1;
                    4: v = '0;
                    default: v = '1;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic test_random_sequences();
        int          mode;
        int          na;
        int          nb;
        logic [31:0] seq_a[$];
        logic [31:0] seq_b[$];
        while (items_sent < 400) begin
            idle_pct = (items_sent >= 150 && items_sent < 260) ? 0 : 20;
            if ($urandom_range(99) < 15) begin
                repeat ($urandom_range(1, 3))
                    send_item(2'($urandom_range(3)), $urandom);
            end else begin
                mode = $urandom_range(2);
                na   = ($urandom_range(9) == 0) ? $urandom_range(20, sai_pkg::DEPTH + 2)
                                                : $urandom_range(8);
                nb   = ($urandom_range(9) == 0) ? $urandom_range(20, sai_pkg::DEPTH + 2)
                                                : $urandom_range(8);
                seq_a.delete();
                seq_b.delete();
                repeat (na)
                    seq_a.push_back(pick_value(mode));
                repeat (nb) begin
                    if (mode == 1 && seq_a.size() > 0 && $urandom_range(1) == 1)
                        seq_b.push_back(seq_a[$urandom_range(seq_a.size() - 1)]);
                    else
                        seq_b.push_back(pick_value(mode));
                end
                while (seq_a.size() > 0 || seq_b.size() > 0) begin
                    if ($urandom_range(19) == 0)
                        send_item(KIND_UNUSED, $urandom);
                    if (seq_b.size() == 0 || (seq_a.size() > 0 && $urandom_range(1) == 0))
                        send_item(sai_pkg::KIND_A, seq_a.pop_front());
                    else
                        send_item(sai_pkg::KIND_B, seq_b.pop_front());
                end
                send_item(sai_pkg::KIND_START, $urandom);
            end
        end
    endtask

    initial begin
        int drain_cycles;
        fail_count       = 0;
        items_sent       = 0;
        idle_pct         = 20;
        overflow_pending = 1'b0;
        drain_cycles     = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_start();
        test_extreme_values();
        test_duplicates_and_unused_kind();
        test_one_list_empty();
        test_full_lists();
        test_random_sequences();

        @(negedge i_clk);
        i_start <= 1'b0;
        while (common_q.size() != 0 && drain_cycles < 10000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (100) @(posedge i_clk);
        if (common_q.size() != 0) begin
            $display("%0t ns: results missing, expected %0d more, actual 0",
                     $time, common_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
